FILE: rtl/psi_pkg.sv
// ----------------------------------------------------------------------------
// psi_pkg
// Shared types and constants for the particle store integrator.
// ----------------------------------------------------------------------------
package psi_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int CNT_W     = 11;
	localparam logic [7:0] OPACITY_FULL = 8'd255;

	typedef enum logic {
		OP_SPAWN = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// spawn payload plus decoded operation
	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [2:0][31:0] acc;
		logic [7:0]       fade;
		logic [15:0]      life;
	} cmd_t;

	// pos, vel, acc of one slot
	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [2:0][31:0] acc;
	} kin_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qout_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SP_RD,
		ST_SP_WR,
		ST_TK_RD,
		ST_TK_EX,
		ST_TK_FREE
	} bstate_t;

endpackage

FILE: rtl/psi_front.sv
// ----------------------------------------------------------------------------
// psi_front
// Accepts decoded commands and holds them in a
// two-word queue until the back end takes them.
// ----------------------------------------------------------------------------
module psi_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  psi_pkg::cmd_t cmd_in,
	output psi_pkg::qout_t qout,
	input  logic          pop
);
	import psi_pkg::*;

	cmd_t       q_mem [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= cmd_in;
	end

	assign qout.valid = (cnt_q != 2'd0);
	assign qout.cmd   = q_mem[rd_ptr_q];

endmodule

FILE: rtl/psi_back.sv
// ----------------------------------------------------------------------------
// psi_back
// Slot store and list engine: spawns into the free list head, walks the
// active list on a tick, integrates survivors and frees expired slots.
// ----------------------------------------------------------------------------
module psi_back #(
	parameter int SLOTS = psi_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psi_pkg::qout_t               qout,
	output logic                         pop,
	output logic                         done,
	output logic                         accepted,
	output logic [psi_pkg::CNT_W-1:0]    active_count,
	output logic [psi_pkg::CNT_W-1:0]    expired_count
);
	import psi_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam logic [PW-1:0] EMPTY = PW'(SLOTS);

	bstate_t state_q, state_d;
	cmd_t    cmd_q;
	logic [PW-1:0] cur_q, prev_q, nxt_q, act_head_q, free_head_q, fill_q, live_q, exp_q;
	logic          have_prev_q;

	// memories
	kin_t        kin_mem  [SLOTS];
	logic [31:0] ofl_mem  [SLOTS];
	logic [PW-1:0] link_mem [SLOTS];
	kin_t          kin_rd;
	logic [31:0]   ofl_rd;
	logic [PW-1:0] link_rd;
	logic [IW-1:0] raddr, link_waddr;
	logic          kin_we, ofl_we, link_we;
	kin_t          kin_wd;
	logic [31:0]   ofl_wd;
	logic [PW-1:0] link_wd;

	always_ff @(posedge clk) begin
		if (kin_we)  kin_mem[cur_q[IW-1:0]] <= kin_wd;
		if (ofl_we)  ofl_mem[cur_q[IW-1:0]] <= ofl_wd;
		if (link_we) link_mem[link_waddr]   <= link_wd;
		kin_rd  <= kin_mem[raddr];
		ofl_rd  <= ofl_mem[raddr];
		link_rd <= link_mem[raddr];
	end

	assign raddr = cur_q[IW-1:0];

	// tick arithmetic
	logic [7:0]  op_old, fade, op_new;
	logic [15:0] life_old, life_dec, life_new;
	logic        borrow, dead;
	kin_t        kin_upd;

	always_comb begin
		op_old   = ofl_rd[31:24];
		fade     = ofl_rd[23:16];
		life_old = ofl_rd[15:0];
		op_new   = op_old - fade;
		borrow   = fade > op_old;
		life_dec = life_old - 16'd1;
		life_new = borrow ? life_old : life_dec;
		dead     = borrow || (life_dec == 16'd0);
		for (int i = 0; i < 3; i++) begin
			kin_upd.pos[i] = kin_rd.pos[i] + kin_rd.vel[i];
			kin_upd.vel[i] = kin_rd.vel[i] + kin_rd.acc[i];
			kin_upd.acc[i] = kin_rd.acc[i];
		end
	end

	// slots at or above fill_q were never handed out; their link is implied
	logic [PW-1:0] spawn_nxt;
	assign spawn_nxt = (cur_q == fill_q) ? fill_q + PW'(1) : link_rd;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (qout.valid) begin
					if (qout.cmd.op == OP_SPAWN)
						state_d = (free_head_q == EMPTY) ? ST_IDLE : ST_SP_RD;
					else
						state_d = (act_head_q == EMPTY) ? ST_IDLE : ST_TK_RD;
				end
			end
			ST_SP_RD:  state_d = ST_SP_WR;
			ST_SP_WR:  state_d = ST_IDLE;
			ST_TK_RD:  state_d = ST_TK_EX;
			ST_TK_EX: begin
				if (dead)                 state_d = ST_TK_FREE;
				else if (link_rd == EMPTY) state_d = ST_IDLE;
				else                      state_d = ST_TK_RD;
			end
			ST_TK_FREE: state_d = (nxt_q == EMPTY) ? ST_IDLE : ST_TK_RD;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs toward memories and queue
	always_comb begin
		pop        = (state_q == ST_IDLE) && qout.valid;
		kin_we     = 1'b0;
		ofl_we     = 1'b0;
		link_we    = 1'b0;
		link_waddr = cur_q[IW-1:0];
		link_wd    = act_head_q;
		kin_wd     = kin_upd;
		ofl_wd     = {op_new, fade, life_new};
		case (state_q)
			ST_SP_WR: begin
				kin_we  = 1'b1;
				ofl_we  = 1'b1;
				link_we = 1'b1;
				kin_wd  = '{pos: cmd_q.pos, vel: cmd_q.vel, acc: cmd_q.acc};
				ofl_wd  = {OPACITY_FULL, cmd_q.fade, cmd_q.life};
			end
			ST_TK_EX: begin
				ofl_we     = 1'b1;
				kin_we     = !dead;
				link_we    = dead && have_prev_q;
				link_waddr = prev_q[IW-1:0];
				link_wd    = link_rd;
			end
			ST_TK_FREE: begin
				link_we = 1'b1;
				link_wd = free_head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= qout.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cur_q         <= '0;
			prev_q        <= '0;
			nxt_q         <= '0;
			have_prev_q   <= 1'b0;
			act_head_q    <= EMPTY;
			free_head_q   <= '0;
			fill_q        <= '0;
			live_q        <= '0;
			exp_q         <= '0;
			done          <= 1'b0;
			accepted      <= 1'b0;
			active_count  <= '0;
			expired_count <= '0;
		end else begin
			state_q  <= state_d;
			done     <= 1'b0;
			accepted <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (qout.valid) begin
						if (qout.cmd.op == OP_SPAWN) begin
							cur_q <= free_head_q;
							if (free_head_q == EMPTY) begin
								done          <= 1'b1;
								active_count  <= CNT_W'(live_q);
								expired_count <= '0;
							end
						end else begin
							cur_q       <= act_head_q;
							have_prev_q <= 1'b0;
							exp_q       <= '0;
							if (act_head_q == EMPTY) begin
								done          <= 1'b1;
								active_count  <= CNT_W'(live_q);
								expired_count <= '0;
							end
						end
					end
				end
				ST_SP_WR: begin
					if (cur_q == fill_q) fill_q <= fill_q + PW'(1);
					free_head_q   <= spawn_nxt;
					act_head_q    <= cur_q;
					live_q        <= live_q + PW'(1);
					done          <= 1'b1;
					accepted      <= 1'b1;
					active_count  <= CNT_W'(live_q + PW'(1));
					expired_count <= '0;
				end
				ST_TK_EX: begin
					if (dead) begin
						if (!have_prev_q) act_head_q <= link_rd;
						nxt_q  <= link_rd;
						live_q <= live_q - PW'(1);
						exp_q  <= exp_q + PW'(1);
					end else begin
						prev_q      <= cur_q;
						have_prev_q <= 1'b1;
						cur_q       <= link_rd;
						if (link_rd == EMPTY) begin
							done          <= 1'b1;
							active_count  <= CNT_W'(live_q);
							expired_count <= CNT_W'(exp_q);
						end
					end
				end
				ST_TK_FREE: begin
					free_head_q <= cur_q;
					cur_q       <= nxt_q;
					if (nxt_q == EMPTY) begin
						done          <= 1'b1;
						active_count  <= CNT_W'(live_q);
						expired_count <= CNT_W'(exp_q);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/particle_store_integrator.sv
// Spawn: ST_SP_RD and ST_SP_WR once it leaves the queue; a refused spawn or an
// empty tick is answered from ST_IDLE. Tick: ST_TK_RD and ST_TK_EX per surviving
// particle, plus ST_TK_FREE per expired one; one shared memory read port.
// A two-word input queue lets start be taken while a tick is still walking.
// Reset: async, active low; free list starts as all slots in order, store empty.
// done is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// particle_store_integrator
// Particle slot store with active and free lists and Euler update per tick.
// ----------------------------------------------------------------------------
module particle_store_integrator #(
	parameter int SLOTS = psi_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic signed [31:0] pos_x_in,
	input  logic signed [31:0] pos_y_in,
	input  logic signed [31:0] pos_z_in,
	input  logic signed [31:0] vel_x_in,
	input  logic signed [31:0] vel_y_in,
	input  logic signed [31:0] vel_z_in,
	input  logic signed [31:0] acc_x_in,
	input  logic signed [31:0] acc_y_in,
	input  logic signed [31:0] acc_z_in,
	input  logic [7:0]         fade_in,
	input  logic [15:0]        life_in,
	output logic               done,
	output logic               accepted,
	output logic [10:0]        active_count,
	output logic [10:0]        expired_count
);
	import psi_pkg::*;

	cmd_t  cmd_in;
	qout_t qout;
	logic  pop;

	always_comb begin
		cmd_in.op   = op_t'(req_type);
		cmd_in.pos  = {pos_z_in, pos_y_in, pos_x_in};
		cmd_in.vel  = {vel_z_in, vel_y_in, vel_x_in};
		cmd_in.acc  = {acc_z_in, acc_y_in, acc_x_in};
		cmd_in.fade = fade_in;
		cmd_in.life = life_in;
	end

	psi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd_in (cmd_in),
		.qout   (qout),
		.pop    (pop)
	);

	psi_back #(.SLOTS(SLOTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qout          (qout),
		.pop           (pop),
		.done          (done),
		.accepted      (accepted),
		.active_count  (active_count),
		.expired_count (expired_count)
	);

endmodule

FILE: rtl/psi_checker.sv
// ----------------------------------------------------------------------------
// psi_checker
// Port-level checks for the particle store integrator.
// ----------------------------------------------------------------------------
module psi_checker #(
	parameter int SLOTS = psi_pkg::SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        accepted,
	input logic [10:0] active_count,
	input logic [10:0] expired_count
);

	a_acc_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		accepted |-> done) else $error("accepted without done");

	a_spawn_no_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (expired_count == 11'd0))
		else $error("spawn reported expirations");

	a_spawn_live: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted && SLOTS < 2048) |-> (active_count != 11'd0))
		else $error("spawn left store empty");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && SLOTS < 2048) |-> (active_count <= 11'(SLOTS)))
		else $error("live count beyond store size");

	// reset clears the strobe and the queue
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> (!done && !busy)) else $error("outputs active in reset");

endmodule

bind particle_store_integrator psi_checker #(.SLOTS(SLOTS)) u_psi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.accepted      (accepted),
	.active_count  (active_count),
	.expired_count (expired_count)
);
